// ===== rtl/csq_pkg.sv =====
package csq_pkg;

  // Command codes carried in the op field.
  localparam logic [3:0] OP_START       = 4'd0;
  localparam logic [3:0] OP_END         = 4'd1;
  localparam logic [3:0] OP_LAST_SLOT   = 4'd2;
  localparam logic [3:0] OP_ADVANCE     = 4'd3;
  localparam logic [3:0] OP_RETREAT     = 4'd4;
  localparam logic [3:0] OP_INSERT      = 4'd5;
  localparam logic [3:0] OP_ATTACH      = 4'd6;
  localparam logic [3:0] OP_REMOVE      = 4'd7;
  localparam logic [3:0] OP_INS_FRONT   = 4'd8;
  localparam logic [3:0] OP_ATT_BACK    = 4'd9;
  localparam logic [3:0] OP_REM_FRONT   = 4'd10;
  localparam logic [3:0] OP_READ_CURSOR = 4'd11;
  localparam logic [3:0] OP_READ_INDEX  = 4'd12;

  // Widest pointer and entry count over the supported depth range.
  localparam int MAX_PTR_BITS = 10;
  localparam int MAX_NUM_BITS = 11;

  typedef struct packed {
    logic [3:0]  op;
    logic [31:0] entry_value;
    logic [4:0]  read_index;
  } cmd_t;

  typedef struct packed {
    logic [31:0] read_value;
    logic [5:0]  item_count;
    logic [4:0]  cursor_pos;
    logic        has_item;
    logic        error;
  } rsp_t;

  // Request to the shift sequencer: move num entries by one slot,
  // starting at address ptr and walking down (up = 1) or up (up = 0).
  typedef struct packed {
    logic                    go;
    logic                    up;
    logic [MAX_PTR_BITS-1:0] ptr;
    logic [MAX_NUM_BITS-1:0] num;
  } shift_req_t;

endpackage

// ===== rtl/cursor_sequence_store_unit.sv =====
// Ordered list of up to DEPTH words with an item count and a cursor. A command
// is taken when start is high and busy is low; its single result word appears
// on result with done high for exactly one cycle and must be captured then.
// Cursor moves and refused commands put their result out in the cycle right
// after acceptance; reads first pass through the store's registered read and
// the read state. Insert, attach, remove and their front and back forms shift
// the entries behind the affected slot one per cycle through the store, which
// has separate read and write ports. For reads and shifts, busy is high from
// the cycle after acceptance until the cycle in which the result is registered.
module cursor_sequence_store_unit #(
  parameter int DEPTH     = 32,
  parameter int WORD_BITS = 32
) (
  input  logic           clk,
  input  logic           rst,
  input  logic           start,
  output logic           busy,
  input  csq_pkg::cmd_t  cmd,
  output logic           done,
  output csq_pkg::rsp_t  result
);

  import csq_pkg::*;

  localparam int AW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);

  localparam logic [1:0] ST_IDLE  = 2'd0;
  localparam logic [1:0] ST_READ  = 2'd1;
  localparam logic [1:0] ST_SHIFT = 2'd2;

  logic [1:0]           state, state_next;
  logic [CW-1:0]        count, count_next;
  logic [AW-1:0]        cursor, cursor_next;
  logic                 ins_mode;
  logic [AW-1:0]        pos;
  logic [WORD_BITS-1:0] word;

  logic                 accept;
  logic                 hc;
  logic                 full;
  logic [CW-1:0]        pos_c;
  logic [63:0]          wide_in;
  logic [63:0]          wide_rd;

  logic                 fin;
  logic                 fin_err;
  logic [31:0]          fin_rd;

  shift_req_t           req;
  logic                 top_re;
  logic [AW-1:0]        top_raddr;
  logic                 top_we;

  logic                 seq_re, seq_we, seq_idle;
  logic [AW-1:0]        seq_raddr, seq_waddr;
  logic [WORD_BITS-1:0] seq_wdata;

  logic                 mem_re, mem_we;
  logic [AW-1:0]        mem_raddr, mem_waddr;
  logic [WORD_BITS-1:0] mem_wdata, mem_q;

  assign accept  = start && !busy;
  assign busy    = (state != ST_IDLE);
  assign hc      = (count != '0) && (CW'(cursor) < count);
  assign full    = (count == CW'(DEPTH));
  assign wide_in = 64'(cmd.entry_value);
  assign wide_rd = 64'(mem_q);

  always_comb begin
    state_next  = state;
    count_next  = count;
    cursor_next = cursor;
    fin         = 1'b0;
    fin_err     = 1'b0;
    fin_rd      = '0;
    req         = '0;
    top_re      = 1'b0;
    top_raddr   = cursor;
    top_we      = 1'b0;
    pos_c       = '0;
    case (state)
      ST_IDLE: begin
        if (accept) begin
          fin = 1'b1;
          case (cmd.op)
            OP_START: cursor_next = '0;
            OP_END: cursor_next = (count != '0) ? AW'(count - CW'(1)) : '0;
            OP_LAST_SLOT: cursor_next = AW'(DEPTH - 1);
            OP_ADVANCE: begin
              if (!hc) begin
                fin_err = 1'b1;
              end else if (cursor != AW'(DEPTH - 1)) begin
                cursor_next = cursor + AW'(1);
              end
            end
            OP_RETREAT: begin
              if (!hc) begin
                fin_err = 1'b1;
              end else if (cursor != '0) begin
                cursor_next = cursor - AW'(1);
              end
            end
            OP_INSERT, OP_ATTACH, OP_INS_FRONT, OP_ATT_BACK: begin
              if (full) begin
                fin_err = 1'b1;
              end else begin
                if (cmd.op == OP_INSERT) begin
                  pos_c = hc ? CW'(cursor) : '0;
                end else if (cmd.op == OP_ATTACH) begin
                  pos_c = hc ? CW'(cursor) + CW'(1) : '0;
                end else if (cmd.op == OP_ATT_BACK) begin
                  pos_c = count;
                end
                fin        = 1'b0;
                state_next = ST_SHIFT;
                req.go     = 1'b1;
                req.up     = 1'b1;
                req.ptr    = MAX_PTR_BITS'(AW'(count - CW'(1)));
                req.num    = MAX_NUM_BITS'(count - pos_c);
              end
            end
            OP_REMOVE: begin
              if (!hc) begin
                fin_err = 1'b1;
              end else begin
                fin        = 1'b0;
                state_next = ST_SHIFT;
                req.go     = 1'b1;
                req.ptr    = MAX_PTR_BITS'(AW'(CW'(cursor) + CW'(1)));
                req.num    = MAX_NUM_BITS'(count - CW'(1) - CW'(cursor));
              end
            end
            OP_REM_FRONT: begin
              if (count == '0) begin
                fin_err = 1'b1;
              end else begin
                fin         = 1'b0;
                cursor_next = '0;
                state_next  = ST_SHIFT;
                req.go      = 1'b1;
                req.ptr     = MAX_PTR_BITS'(1);
                req.num     = MAX_NUM_BITS'(count - CW'(1));
              end
            end
            OP_READ_CURSOR: begin
              if (!hc) begin
                fin_err = 1'b1;
              end else begin
                fin        = 1'b0;
                top_re     = 1'b1;
                state_next = ST_READ;
              end
            end
            OP_READ_INDEX: begin
              if (32'(cmd.read_index) >= 32'(count)) begin
                fin_err = 1'b1;
              end else begin
                fin        = 1'b0;
                top_re     = 1'b1;
                top_raddr  = AW'(cmd.read_index);
                state_next = ST_READ;
              end
            end
            default: fin_err = 1'b1;
          endcase
        end
      end
      ST_READ: begin
        fin        = 1'b1;
        fin_rd     = wide_rd[31:0];
        state_next = ST_IDLE;
      end
      ST_SHIFT: begin
        if (seq_idle) begin
          fin        = 1'b1;
          state_next = ST_IDLE;
          if (ins_mode) begin
            // The gap is open: drop the new word in and point at it.
            top_we      = 1'b1;
            count_next  = count + CW'(1);
            cursor_next = pos;
          end else begin
            count_next = count - CW'(1);
          end
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state  <= ST_IDLE;
      count  <= '0;
      cursor <= '0;
      done   <= 1'b0;
    end else begin
      state  <= state_next;
      count  <= count_next;
      cursor <= cursor_next;
      done   <= fin;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      ins_mode <= (cmd.op == OP_INSERT) || (cmd.op == OP_ATTACH) ||
                  (cmd.op == OP_INS_FRONT) || (cmd.op == OP_ATT_BACK);
      pos      <= AW'(pos_c);
      word     <= wide_in[WORD_BITS-1:0];
    end
    if (fin) begin
      result.read_value <= fin_rd;
      result.item_count <= 6'(count_next);
      result.cursor_pos <= 5'(cursor_next);
      result.has_item   <= (count_next != '0) && (CW'(cursor_next) < count_next);
      result.error      <= fin_err;
    end
  end

  assign mem_re    = seq_re || top_re;
  assign mem_raddr = seq_re ? seq_raddr : top_raddr;
  assign mem_we    = seq_we || top_we;
  assign mem_waddr = seq_we ? seq_waddr : pos;
  assign mem_wdata = seq_we ? seq_wdata : word;

  csq_shift #(
    .WORD_BITS (WORD_BITS),
    .AW        (AW),
    .CW        (CW)
  ) u_shift (
    .clk   (clk),
    .rst   (rst),
    .req   (req),
    .mem_q (mem_q),
    .re    (seq_re),
    .raddr (seq_raddr),
    .we    (seq_we),
    .waddr (seq_waddr),
    .wdata (seq_wdata),
    .idle  (seq_idle)
  );

  csq_store #(
    .DEPTH     (DEPTH),
    .WORD_BITS (WORD_BITS),
    .AW        (AW)
  ) u_store (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .re    (mem_re),
    .raddr (mem_raddr),
    .rdata (mem_q)
  );

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= CW'(DEPTH))
    else $error("item count exceeds store depth");

  a_shift_only_when_busy: assert property (@(posedge clk) disable iff (rst)
    (seq_we || seq_re) |-> (state == ST_SHIFT))
    else $error("shift traffic outside a shift command");

  a_write_exclusive: assert property (@(posedge clk) disable iff (rst)
    !(seq_we && top_we))
    else $error("shift write collides with final entry write");

  a_accept_progress: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |=> (done || busy))
    else $error("accepted command produced neither a result nor work");

endmodule

// ===== rtl/csq_store.sv =====
module csq_store #(
  parameter int DEPTH     = 32,
  parameter int WORD_BITS = 32,
  parameter int AW        = 5
) (
  input  logic                 clk,
  input  logic                 we,
  input  logic [AW-1:0]        waddr,
  input  logic [WORD_BITS-1:0] wdata,
  input  logic                 re,
  input  logic [AW-1:0]        raddr,
  output logic [WORD_BITS-1:0] rdata
);

  logic [WORD_BITS-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ===== rtl/csq_shift.sv =====
module csq_shift #(
  parameter int WORD_BITS = 32,
  parameter int AW        = 5,
  parameter int CW        = 6
) (
  input  logic                    clk,
  input  logic                    rst,
  input  csq_pkg::shift_req_t     req,
  input  logic [WORD_BITS-1:0]    mem_q,
  output logic                    re,
  output logic [AW-1:0]           raddr,
  output logic                    we,
  output logic [AW-1:0]           waddr,
  output logic [WORD_BITS-1:0]    wdata,
  output logic                    idle
);

  import csq_pkg::*;

  logic [CW-1:0] left;
  logic          pend;
  logic          up;
  logic [AW-1:0] ptr;
  logic [AW-1:0] dst;

  // One entry is read per cycle; its word comes back in the next cycle and is
  // written one slot over, while the next read is already under way.
  always_ff @(posedge clk) begin
    if (rst) begin
      left <= '0;
      pend <= 1'b0;
    end else if (req.go) begin
      left <= CW'(req.num);
      pend <= 1'b0;
    end else begin
      pend <= (left != '0);
      if (left != '0) begin
        left <= left - CW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (req.go) begin
      up  <= req.up;
      ptr <= AW'(req.ptr);
    end else if (left != '0) begin
      ptr <= up ? ptr - AW'(1) : ptr + AW'(1);
      dst <= up ? ptr + AW'(1) : ptr - AW'(1);
    end
  end

  assign re    = !req.go && (left != '0);
  assign raddr = ptr;
  assign we    = pend;
  assign waddr = dst;
  assign wdata = mem_q;
  assign idle  = (left == '0) && !pend;

endmodule

// ===== sim/tb.sv =====
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  import csq_pkg::*;

  localparam int STORE_DEPTH = 32;
  localparam int RANDOM_ITEMS = 1300;
  localparam int SETTLE_CYCLES = STORE_DEPTH + 8;
  localparam int MAX_PRINTED = 40;
  // Codes above the last command are undefined and must be refused.
  localparam logic [3:0] OP_SPARE_LO = OP_READ_INDEX + 4'd1;
  localparam logic [3:0] OP_SPARE_HI = 4'hF;

  // Tracks the list contents, predicts each result word and checks it.
  class seq_scoreboard;
    logic [31:0] words [STORE_DEPTH];
    int unsigned n_items;
    int unsigned n_cursor;
    rsp_t pending [$];
    int errors;
    int n_cmds;
    int n_effective;
    int n_checked;
    int full_hits;
    int empty_hits;

    function bit holds_item();
      return n_items > 0 && n_cursor < n_items;
    endfunction

    // Opens a slot at pos by moving later entries up; the cursor lands on it.
    function void place(int unsigned pos, logic [31:0] w);
      for (int unsigned i = n_items; i > pos; i--) words[i] = words[i - 1];
      words[pos] = w;
      n_items++;
      n_cursor = pos;
    endfunction

    function void take_out();
      for (int unsigned i = n_cursor; i + 1 < n_items; i++) words[i] = words[i + 1];
      n_items--;
    endfunction

    function void report(string msg);
      errors++;
      if (errors <= MAX_PRINTED) $display("MISMATCH: %s", msg);
    endfunction

    function void compare(string name, logic [31:0] got, logic [31:0] want);
      if (got !== want)
        report($sformatf("word %0d %s got %h expected %h", n_checked, name, got, want));
    endfunction

    // Records an accepted command and returns 1 when it should be refused.
    function bit note(cmd_t c);
      rsp_t r;
      bit full;
      int unsigned was_items;
      r = '0;
      full = n_items >= STORE_DEPTH;
      was_items = n_items;
      case (c.op)
        OP_START: n_cursor = 0;
        OP_END: n_cursor = n_items > 0 ? n_items - 1 : 0;
        OP_LAST_SLOT: n_cursor = STORE_DEPTH - 1;
        OP_ADVANCE: begin
          if (!holds_item()) r.error = 1'b1;
          else if (n_cursor != STORE_DEPTH - 1) n_cursor++;
        end
        OP_RETREAT: begin
          if (!holds_item()) r.error = 1'b1;
          else if (n_cursor != 0) n_cursor--;
        end
        OP_INSERT: begin
          if (full) r.error = 1'b1;
          else place(holds_item() ? n_cursor : 0, c.entry_value);
        end
        OP_ATTACH: begin
          if (full) r.error = 1'b1;
          else place(holds_item() ? n_cursor + 1 : 0, c.entry_value);
        end
        OP_REMOVE: begin
          if (!holds_item()) r.error = 1'b1;
          else take_out();
        end
        OP_INS_FRONT: begin
          if (full) r.error = 1'b1;
          else place(0, c.entry_value);
        end
        OP_ATT_BACK: begin
          if (full) r.error = 1'b1;
          else place(n_items, c.entry_value);
        end
        OP_REM_FRONT: begin
          if (n_items == 0) r.error = 1'b1;
          else begin
            n_cursor = 0;
            take_out();
          end
        end
        OP_READ_CURSOR: begin
          if (!holds_item()) r.error = 1'b1;
          else r.read_value = words[n_cursor];
        end
        OP_READ_INDEX: begin
          if (c.read_index >= n_items) r.error = 1'b1;
          else r.read_value = words[c.read_index];
        end
        default: r.error = 1'b1;
      endcase
      r.item_count = n_items[5:0];
      r.cursor_pos = n_cursor[4:0];
      r.has_item = holds_item();
      pending.push_back(r);
      n_cmds++;
      if (!r.error) n_effective++;
      if (was_items < STORE_DEPTH && n_items == STORE_DEPTH) full_hits++;
      if (was_items > 0 && n_items == 0) empty_hits++;
      return r.error;
    endfunction

    function void check(rsp_t got);
      rsp_t want;
      if (pending.size() == 0) begin
        report($sformatf("result %h arrived with no command waiting", got));
        return;
      end
      want = pending.pop_front();
      compare("read_value", got.read_value, want.read_value);
      compare("item_count", 32'(got.item_count), 32'(want.item_count));
      compare("cursor_pos", 32'(got.cursor_pos), 32'(want.cursor_pos));
      compare("has_item", 32'(got.has_item), 32'(want.has_item));
      compare("error", 32'(got.error), 32'(want.error));
      n_checked++;
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic start = 1'b0;
  cmd_t cmd = '0;
  logic busy;
  logic done;
  rsp_t result;

  seq_scoreboard sb = new();
  bit growing = 1'b1;

  cursor_sequence_store_unit #(
    .DEPTH(STORE_DEPTH),
    .WORD_BITS(32)
  ) dut (
    .clk(clk),
    .rst(rst),
    .start(start),
    .busy(busy),
    .cmd(cmd),
    .done(done),
    .result(result)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  always @(posedge clk) begin
    if (!rst && done) sb.check(result);
  end

  // Holds start high until the word is taken; start stays high afterwards so
  // a following call continues the burst without a dead cycle.
  task automatic send(input cmd_t c);
    cmd <= c;
    start <= 1'b1;
    do @(posedge clk); while (busy);
    void'(sb.note(c));
  endtask

  task automatic pause(input int n);
    start <= 1'b0;
    repeat (n) @(posedge clk);
  endtask

  task automatic drain();
    start <= 1'b0;
    do @(posedge clk); while (sb.pending.size() != 0);
  endtask

  // Mostly grows or shrinks the list depending on the current trend, with
  // cursor moves, reads and a trickle of undefined codes mixed in.
  function automatic cmd_t next_cmd();
    cmd_t c;
    int unsigned r;
    int unsigned top;
    c.entry_value = $urandom();
    c.read_index = 5'($urandom_range(0, STORE_DEPTH - 1));
    r = $urandom_range(0, 99);
    if (r < 55) begin
      if ((r < 45) == growing) begin
        case ($urandom_range(0, 3))
          0: c.op = OP_INSERT;
          1: c.op = OP_ATTACH;
          2: c.op = OP_INS_FRONT;
          default: c.op = OP_ATT_BACK;
        endcase
      end else begin
        c.op = ($urandom_range(0, 2) == 0) ? OP_REM_FRONT : OP_REMOVE;
      end
    end else if (r < 75) begin
      c.op = 4'($urandom_range(OP_START, OP_RETREAT));
    end else if (r < 97) begin
      c.op = $urandom_range(0, 1) ? OP_READ_CURSOR : OP_READ_INDEX;
      if (c.op == OP_READ_INDEX && $urandom_range(0, 3) != 0) begin
        top = (sb.n_items < STORE_DEPTH) ? sb.n_items : STORE_DEPTH - 1;
        c.read_index = 5'($urandom_range(0, top));
      end
    end else begin
      c.op = 4'($urandom_range(OP_SPARE_LO, OP_SPARE_HI));
    end
    return c;
  endfunction

  initial begin
    int goal;
    int burst;
    int since_drain;
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Empty list: everything that needs an item is refused.
    send('{OP_READ_INDEX, 32'h0, 5'd0});
    send('{OP_READ_CURSOR, 32'h0, 5'd0});
    send('{OP_ADVANCE, 32'h0, 5'd0});
    send('{OP_RETREAT, 32'h0, 5'd0});
    send('{OP_REMOVE, 32'h0, 5'd0});
    send('{OP_REM_FRONT, 32'h0, 5'd0});
    send('{OP_END, 32'h0, 5'd0});
    send('{OP_LAST_SLOT, 32'h0, 5'd31});
    // With no current item, insert and attach both go to the front.
    send('{OP_INSERT, 32'hFFFF_FFFF, 5'd31});
    send('{OP_LAST_SLOT, 32'h0, 5'd0});
    send('{OP_ATTACH, 32'h0000_0000, 5'd0});
    send('{OP_ATT_BACK, 32'hA5A5_A5A5, 5'd0});
    send('{OP_INS_FRONT, 32'h5A5A_5A5A, 5'd0});
    send('{OP_RETREAT, 32'h0, 5'd0});
    send('{OP_ADVANCE, 32'h0, 5'd0});
    send('{OP_INSERT, 32'h1234_5678, 5'd0});
    send('{OP_ATTACH, 32'h8765_4321, 5'd0});
    send('{OP_END, 32'h0, 5'd0});
    // Removing the last item leaves the cursor past the end.
    send('{OP_REMOVE, 32'h0, 5'd0});
    send('{OP_READ_CURSOR, 32'h0, 5'd0});
    send('{OP_READ_INDEX, 32'h0, 5'd4});
    send('{OP_READ_INDEX, 32'h0, 5'd31});
    send('{OP_START, 32'h0, 5'd0});
    send('{OP_READ_CURSOR, 32'h0, 5'd0});
    send('{OP_SPARE_LO, 32'h0, 5'd0});
    send('{OP_SPARE_HI, 32'hFFFF_FFFF, 5'd31});
    drain();

    goal = sb.n_cmds + RANDOM_ITEMS;

    // Fill to the top with random words and probe the full store.
    while (sb.n_items < STORE_DEPTH) send('{OP_ATT_BACK, $urandom(), 5'd0});
    send('{OP_END, 32'h0, 5'd0});
    send('{OP_ADVANCE, 32'h0, 5'd0});
    send('{OP_INSERT, $urandom(), 5'd0});
    send('{OP_READ_INDEX, 32'h0, 5'd31});
    growing = 1'b0;
    pause($urandom_range(1, 10));

    since_drain = 0;
    while (sb.n_cmds < goal) begin
      burst = $urandom_range(1, 24);
      repeat (burst) begin
        send(next_cmd());
        if (growing && sb.n_items == STORE_DEPTH && $urandom_range(0, 7) == 0) growing = 1'b0;
        else if (!growing && sb.n_items == 0 && $urandom_range(0, 3) == 0) growing = 1'b1;
        else if ($urandom_range(0, 199) == 0) growing = !growing;
      end
      since_drain += burst;
      if (since_drain > 250) begin
        drain();
        since_drain = 0;
      end else if ($urandom_range(0, 3) != 0) begin
        pause($urandom_range(0, 1) ? $urandom_range(1, 4) : $urandom_range(5, 40));
      end
    end

    drain();
    repeat (SETTLE_CYCLES) @(posedge clk);

    $display("Ran %0d commands, %0d took effect, %0d result words checked",
             sb.n_cmds, sb.n_effective, sb.n_checked);
    $display("List filled to capacity %0d times and emptied %0d times",
             sb.full_hits, sb.empty_hits);
    if (sb.errors == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

  initial begin
    #20ms;
    $display("DONE: errors detected");
    $finish;
  end

endmodule
